// ===== hdl/assert_macros.svh =====
// assertion helpers, clocked on clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset too
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/sgdmu_pkg.sv =====
`default_nettype none

package sgdmu_pkg;

  localparam int DEF_VELOCITY_DEPTH = 1024;

  localparam int VALUE_W = 32;
  localparam int COEF_W  = 16;
  localparam int SLOT_W  = 10;
  localparam int CFG_IDX_W = 2;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOMENTUM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 2'd2;

  localparam logic [COEF_W-1:0] STEP_RATE_RST = 16'd655;
  localparam logic [COEF_W-1:0] MOMENTUM_RST  = 16'd0;
  localparam logic [COEF_W-1:0] DECAY_RST     = 16'd0;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] val;
  } sat_t;

  // clamp a 34-bit signed value to 32 bits
  function automatic sat_t sat34(input logic signed [33:0] x);
    sat_t r;
    if (x[33:31] == 3'b000 || x[33:31] == 3'b111) begin
      r.hit = 1'b0;
      r.val = x[31:0];
    end else begin
      r.hit = 1'b1;
      r.val = x[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sgd_momentum_weight_update.sv =====
// an accepted word passes the stage 1 to stage 4 registers and the output register in turn
// throughput: one word per cycle when the output does not stall, also for back-to-back
// words at one slot (velocity read-modify-write closes through write-stage forwarding)
// reset: synchronous; registers return to their defaults, then the velocity memory is
// swept to zero, one entry per cycle, with s_axis_tready low until the sweep ends
`default_nettype none
`include "assert_macros.svh"

module sgd_momentum_weight_update #(
  parameter int VELOCITY_DEPTH = sgdmu_pkg::DEF_VELOCITY_DEPTH
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [sgdmu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sgdmu_pkg::COEF_W-1:0]        cfg_data,
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  // weight_in, gradient_in, slot_address, zero pad
  input  wire logic [sgdmu_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // fresh_start
  input  wire logic                                s_axis_tuser,
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // weight_out, slot_echo, zero pad
  output      logic [sgdmu_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // clipped
  output      logic                                m_axis_tuser
);

  import sgdmu_pkg::*;

  localparam int AW = (VELOCITY_DEPTH > 1) ? $clog2(VELOCITY_DEPTH) : 1;
  localparam int RW = AW + 1;
  localparam int MOD_RECIP = (1 << 20) / VELOCITY_DEPTH;

  // configuration
  logic [COEF_W-1:0] step_rate;
  logic [COEF_W-1:0] momentum_factor;
  logic [COEF_W-1:0] decay_factor;
  logic              mom_nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_rate       <= STEP_RATE_RST;
      momentum_factor <= MOMENTUM_RST;
      decay_factor    <= DECAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_RATE: step_rate       <= cfg_data;
        REG_MOMENTUM:  momentum_factor <= cfg_data;
        REG_DECAY:     decay_factor    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign mom_nz = (momentum_factor != '0);

  // input unpack
  logic signed [31:0] in_weight;
  logic signed [31:0] in_grad;
  logic [SLOT_W-1:0]  in_slot;

  assign in_weight = s_axis_tdata[31:0];
  assign in_grad   = s_axis_tdata[63:32];
  assign in_slot   = s_axis_tdata[73:64];

  // slot modulo depth: reciprocal estimate, then one correction
  logic [31:0]   mod_prod;
  logic [11:0]   mod_q;
  logic [RW-1:0] mod_rem;
  logic [AW-1:0] in_idx;

  always_comb begin
    mod_prod = 32'(in_slot) * 32'(MOD_RECIP);
    mod_q    = mod_prod[31:20];
    mod_rem  = RW'(in_slot) - RW'(32'(mod_q) * 32'(VELOCITY_DEPTH));
    if (mod_rem >= RW'(VELOCITY_DEPTH)) begin
      in_idx = AW'(mod_rem - RW'(VELOCITY_DEPTH));
    end else begin
      in_idx = AW'(mod_rem);
    end
  end

  // pipeline control
  logic clearing;
  logic [AW-1:0] clr_cnt;
  logic v1, v2, v3, v4, ov;
  logic rdy1, rdy2, rdy3, rdy4, rdy_o;
  logic in_acc;
  logic we_s2;

  assign rdy_o = !ov || m_axis_tready;
  assign rdy4  = !v4 || rdy_o;
  assign rdy3  = !v3 || rdy4;
  assign rdy2  = !v2 || rdy3;
  assign rdy1  = !v1 || rdy2;

  assign s_axis_tready = rdy1 && !clearing;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign we_s2         = v2 && rdy3 && mom_nz;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == AW'(VELOCITY_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (rdy1)  v1 <= in_acc;
      if (rdy2)  v2 <= v1;
      if (rdy3)  v3 <= v2;
      if (rdy4)  v4 <= v3;
      if (rdy_o) ov <= v4;
    end
  end

  // velocity memory
  logic [31:0]   vel_mem [VELOCITY_DEPTH];
  logic [31:0]   mem_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0]   mem_wd;
  logic [AW-1:0] mem_ra;

  logic [AW-1:0]      s1_idx;
  logic [AW-1:0]      s2_idx;
  logic signed [31:0] s2_vnew;

  assign mem_we = clearing || we_s2;
  assign mem_wa = clearing ? clr_cnt : s2_idx;
  assign mem_wd = clearing ? '0 : s2_vnew;
  assign mem_ra = rdy1 ? in_idx : s1_idx;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vel_mem[mem_wa] <= mem_wd;
    end
    mem_q <= vel_mem[mem_ra];
  end

  // last write, for the read issued at the same edge
  logic          lw_valid;
  logic [AW-1:0] lw_idx;
  logic [31:0]   lw_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else begin
      lw_valid <= we_s2;
    end
  end

  always_ff @(posedge clk) begin
    lw_idx  <= s2_idx;
    lw_data <= s2_vnew;
  end

  // stage 1: decay and momentum products
  logic signed [31:0] s1_w, s1_grad;
  logic [SLOT_W-1:0]  s1_slot;
  logic               s1_fresh;
  logic signed [31:0] vold;
  logic signed [48:0] dprod, mprod;
  logic signed [31:0] dfl, mfl;
  logic signed [32:0] g_c;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_w     <= in_weight;
      s1_grad  <= in_grad;
      s1_slot  <= in_slot;
      s1_idx   <= in_idx;
      s1_fresh <= s_axis_tuser;
    end
  end

  always_comb begin
    if (s1_fresh) begin
      vold = '0;
    end else if (v2 && s2_idx == s1_idx) begin
      vold = s2_vnew;
    end else if (lw_valid && lw_idx == s1_idx) begin
      vold = lw_data;
    end else begin
      vold = mem_q;
    end
    dprod = $signed({1'b0, decay_factor}) * s1_w;
    mprod = $signed({1'b0, momentum_factor}) * vold;
    dfl   = dprod[47:16];
    mfl   = mprod[47:16];
    g_c   = $signed({s1_grad[31], s1_grad}) + $signed({dfl[31], dfl});
  end

  // stage 2: new velocity, written back as it leaves when the momentum factor is nonzero
  logic signed [31:0] s2_w;
  logic [SLOT_W-1:0]  s2_slot;
  logic signed [32:0] s2_g;
  logic signed [31:0] s2_mfl;
  sat_t               vsat;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_w    <= s1_w;
      s2_slot <= s1_slot;
      s2_idx  <= s1_idx;
      s2_g    <= g_c;
      s2_mfl  <= mfl;
    end
  end

  always_comb begin
    vsat    = sat34($signed({s2_g[32], s2_g}) + $signed({{2{s2_mfl[31]}}, s2_mfl}));
    s2_vnew = vsat.val;
  end

  // stage 3: step product
  logic signed [31:0] s3_w;
  logic [SLOT_W-1:0]  s3_slot;
  logic signed [32:0] s3_x;
  logic               s3_hit;
  logic signed [49:0] rprod;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_w    <= s2_w;
      s3_slot <= s2_slot;
      s3_x    <= mom_nz ? {s2_vnew[31], s2_vnew} : s2_g;
      s3_hit  <= mom_nz && vsat.hit;
    end
  end

  assign rprod = $signed({1'b0, step_rate}) * s3_x;

  // stage 4: weight update
  logic signed [31:0] s4_w;
  logic [SLOT_W-1:0]  s4_slot;
  logic signed [32:0] s4_step;
  logic               s4_hit;
  sat_t               wsat;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_w    <= s3_w;
      s4_slot <= s3_slot;
      s4_step <= rprod[48:16];
      s4_hit  <= s3_hit;
    end
  end

  assign wsat = sat34($signed({{2{s4_w[31]}}, s4_w}) - $signed({s4_step[32], s4_step}));

  // output register
  logic signed [31:0] o_weight;
  logic [SLOT_W-1:0]  o_slot;
  logic               o_clip;

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      o_weight <= wsat.val;
      o_slot   <= s4_slot;
      o_clip   <= s4_hit || wsat.hit;
    end
  end

  assign m_axis_tvalid = ov;
  assign m_axis_tdata  = {6'b0, o_slot, o_weight};
  assign m_axis_tuser  = o_clip;

  `ASSERT_CLK(a_clear_pipe_empty, clearing |-> !(v1 || v2 || v3 || v4 || ov), "word in flight during clear")
  `ASSERT_CLK(a_clear_len, $fell(clearing) |-> ($past(clr_cnt) == AW'(VELOCITY_DEPTH - 1)), "clear sweep length wrong")
  `ASSERT_CLK(a_s1_hold, (v1 && !rdy1) |=> (v1 && $stable(s1_idx)), "stage 1 lost its word on stall")
  `ASSERT_CLK_ALWAYS(a_no_write_in_reset, rst |=> !we_s2, "velocity write right after reset")

endmodule

`default_nettype wire
